// ===== design/tri_element_stiffness_assert.svh =====
// Assertion macros for the triangle element stiffness block.
// Used by tes_back; no other dependencies.
`ifndef TRI_ELEMENT_STIFFNESS_ASSERT_SVH
`define TRI_ELEMENT_STIFFNESS_ASSERT_SVH
`ifndef SYNTH
`define TES_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define TES_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define TES_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define TES_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== design/tes_pkg.sv =====
// Shared types and constants of the triangle element stiffness block.
// No dependencies.
`default_nettype none
package tes_pkg;
    localparam int COORD_W = 32;
    localparam int DIFF_W  = 33;
    localparam int NODE_W  = 16;
    localparam int VAL_W   = 48;
    localparam int PAIRS   = 6;

    typedef struct packed {
        logic [2:0][DIFF_W-1:0] ex;
        logic [2:0][DIFF_W-1:0] ey;
        logic [2:0][NODE_W-1:0] node;
    } elem_t;

    function automatic logic [1:0] pair_a(input logic [2:0] k);
        case (k)
            3'd0: pair_a = 2'd0;
            3'd1: pair_a = 2'd1;
            3'd2: pair_a = 2'd0;
            3'd3: pair_a = 2'd0;
            3'd4: pair_a = 2'd1;
            3'd5: pair_a = 2'd2;
            default: pair_a = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] pair_b(input logic [2:0] k);
        case (k)
            3'd0: pair_b = 2'd1;
            3'd1: pair_b = 2'd2;
            3'd2: pair_b = 2'd2;
            3'd3: pair_b = 2'd0;
            3'd4: pair_b = 2'd1;
            3'd5: pair_b = 2'd2;
            default: pair_b = 2'd0;
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== design/tes_front.sv =====
// Front stage: takes a triangle request, forms edge vectors, masks node indices.
// Depends on tes_pkg.
`default_nettype none
module tes_front #(
    parameter int NODE_INDEX_BITS = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [239:0]            in_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output tes_pkg::elem_t               out_elem
);
    localparam logic [15:0] NODE_MASK = (NODE_INDEX_BITS >= 16) ? 16'hFFFF
                                      : 16'((32'd1 << NODE_INDEX_BITS) - 32'd1);

    logic           valid_reg, valid_next;
    tes_pkg::elem_t elem_reg, elem_next;
    logic [2:0][32:0] xs, ys;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            xs[i] = {in_data[64*i+31], in_data[64*i +: 32]};
            ys[i] = {in_data[64*i+63], in_data[64*i+32 +: 32]};
        end
        elem_next = elem_reg;
        for (int i = 0; i < 3; i++) begin
            elem_next.ex[i]   = ys[(i+1)%3] - ys[(i+2)%3];
            elem_next.ey[i]   = xs[(i+2)%3] - xs[(i+1)%3];
            elem_next.node[i] = in_data[192+16*i +: 16] & NODE_MASK;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_elem  = elem_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_valid && in_ready) begin
            elem_reg <= elem_next;
        end
    end
endmodule
`default_nettype wire

// ===== design/tes_queue.sv =====
// Two-entry queue of prepared triangles between front and back.
// Depends on tes_pkg.
`default_nettype none
module tes_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push_valid,
    output logic             push_ready,
    input  tes_pkg::elem_t   push_elem,
    output logic             pop_valid,
    input  wire logic        pop_ready,
    output tes_pkg::elem_t   pop_elem
);
    tes_pkg::elem_t mem_reg [2];
    logic       wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_elem   = mem_reg[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_next  = push ? !wr_reg : wr_reg;
        rd_next  = pop ? !rd_reg : rd_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_reg] <= push_elem;
        end
    end
endmodule
`default_nettype wire

// ===== design/tes_back.sv =====
// Back stage: shared multiplier, determinant, dot products, radix-2 divider,
// rounding, saturation and output register. Depends on tes_pkg and the assert header.
`default_nettype none
`include "tri_element_stiffness_assert.svh"
module tes_back (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  tes_pkg::elem_t   in_elem,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_DET0, ST_DET1, ST_DET2, ST_DOT0, ST_DOT1, ST_DOT2, ST_DIV, ST_OUT
    } state_t;

    state_t                st_reg, st_next;
    tes_pkg::elem_t        cur_reg, cur_next;
    logic [2:0]            k_reg, k_next;
    logic signed [65:0]    prod_reg, prod_next, acc_reg, acc_next;
    logic [66:0]           absdet_reg, absdet_next;
    logic                  degen_reg, degen_next, neg_reg, neg_next, sat_reg, sat_next;
    logic [67:0]           p_reg, p_next;
    logic [47:0]           nlow_reg, nlow_next, q_reg, q_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic                  ov_reg, ov_next;
    logic [79:0]           od_reg, od_next;
    logic                  ol_reg, ol_next, ou_reg, ou_next;

    logic signed [32:0]    ma, mb;
    logic [1:0]            ia, ib;
    logic signed [66:0]    det_w, dot_w;
    logic [66:0]           mag_w;
    logic [90:0]           num_w;
    logic [67:0]           den_w;
    logic [68:0]           t_w;
    logic                  ge_w, out_free;
    logic [47:0]           val_w;
    logic [15:0]           na, nb;

    assign ia       = tes_pkg::pair_a(k_reg);
    assign ib       = tes_pkg::pair_b(k_reg);
    assign den_w    = {absdet_reg, 1'b0};
    assign det_w    = {acc_reg[65], acc_reg} - {prod_reg[65], prod_reg};
    assign dot_w    = {acc_reg[65], acc_reg} + {prod_reg[65], prod_reg};
    assign mag_w    = dot_w[66] ? 67'(-dot_w) : 67'(dot_w);
    assign num_w    = {mag_w[66:0], 24'd0} + {24'd0, absdet_reg};
    assign t_w      = {p_reg, nlow_reg[47]};
    assign ge_w     = t_w >= {1'b0, den_w};
    assign out_free = !ov_reg || m_tready;
    assign in_ready = (st_reg == ST_IDLE);
    assign na       = cur_reg.node[ia];
    assign nb       = cur_reg.node[ib];
    assign prod_next = ma * mb;

    always_comb begin
        case (st_reg)
            ST_DET0: begin ma = $signed(cur_reg.ey[2]); mb = $signed(cur_reg.ex[1]); end
            ST_DET1: begin ma = $signed(cur_reg.ey[1]); mb = $signed(cur_reg.ex[2]); end
            ST_DOT0: begin ma = $signed(cur_reg.ex[ia]); mb = $signed(cur_reg.ex[ib]); end
            ST_DOT1: begin ma = $signed(cur_reg.ey[ia]); mb = $signed(cur_reg.ey[ib]); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    always_comb begin
        if (degen_reg) begin
            val_w = '0;
        end else if (neg_reg) begin
            val_w = (sat_reg || (q_reg > 48'h800000000000)) ? 48'h800000000000
                                                           : 48'(-q_reg);
        end else begin
            val_w = (sat_reg || q_reg[47]) ? 48'h7FFFFFFFFFFF : q_reg;
        end
    end

    always_comb begin
        st_next     = st_reg;
        cur_next    = cur_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        absdet_next = absdet_reg;
        degen_next  = degen_reg;
        neg_next    = neg_reg;
        sat_next    = sat_reg;
        p_next      = p_reg;
        nlow_next   = nlow_reg;
        q_next      = q_reg;
        cnt_next    = cnt_reg;
        ov_next     = ov_reg && !m_tready;
        od_next     = od_reg;
        ol_next     = ol_reg;
        ou_next     = ou_reg;
        case (st_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cur_next = in_elem;
                    st_next  = ST_DET0;
                end
            end
            ST_DET0: st_next = ST_DET1;
            ST_DET1: begin
                acc_next = prod_reg;
                st_next  = ST_DET2;
            end
            ST_DET2: begin
                degen_next  = (det_w == '0);
                absdet_next = det_w[66] ? 67'(-det_w) : 67'(det_w);
                k_next      = 3'd0;
                st_next     = ST_DOT0;
            end
            ST_DOT0: st_next = ST_DOT1;
            ST_DOT1: begin
                acc_next = prod_reg;
                st_next  = ST_DOT2;
            end
            ST_DOT2: begin
                neg_next  = dot_w[66];
                sat_next  = {25'd0, num_w[90:48]} >= den_w;
                p_next    = {25'd0, num_w[90:48]};
                nlow_next = num_w[47:0];
                q_next    = '0;
                cnt_next  = 6'd47;
                st_next   = (degen_reg || ({25'd0, num_w[90:48]} >= den_w)) ? ST_OUT
                                                                             : ST_DIV;
            end
            ST_DIV: begin
                p_next    = ge_w ? 68'(t_w - {1'b0, den_w}) : t_w[67:0];
                q_next    = {q_reg[46:0], ge_w};
                nlow_next = {nlow_reg[46:0], 1'b0};
                cnt_next  = cnt_reg - 6'd1;
                if (cnt_reg == 6'd0) begin
                    st_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    ov_next = 1'b1;
                    od_next = {val_w, (na > nb) ? nb : na, (na > nb) ? na : nb};
                    ol_next = (k_reg == 3'd5);
                    ou_next = degen_reg;
                    if (k_reg == 3'd5) begin
                        st_next = ST_IDLE;
                    end else begin
                        k_next  = k_reg + 3'd1;
                        st_next = ST_DOT0;
                    end
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            k_reg  <= 3'd0;
        end else begin
            st_reg <= st_next;
            ov_reg <= ov_next;
            k_reg  <= k_next;
        end
        cur_reg    <= cur_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        absdet_reg <= absdet_next;
        degen_reg  <= degen_next;
        neg_reg    <= neg_next;
        sat_reg    <= sat_next;
        p_reg      <= p_next;
        nlow_reg   <= nlow_next;
        q_reg      <= q_next;
        cnt_reg    <= cnt_next;
        od_reg     <= od_next;
        ol_reg     <= ol_next;
        ou_reg     <= ou_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tlast  = ol_reg;
    assign m_tuser  = ou_reg;

    `TES_ASSERT_IMP(a_div_live, aclk, aresetn, st_reg == ST_DIV, !degen_reg && !sat_reg, "divide on degenerate or saturated pair")
    `TES_ASSERT_IMP(a_rem_bound, aclk, aresetn, st_reg == ST_DIV, p_reg < den_w, "partial remainder out of range")
    `TES_ASSERT_NXT(a_det_seq, aclk, aresetn, st_reg == ST_DET0, st_reg == ST_DET1, "determinant sequence broken")
    `TES_ASSERT_NXT(a_div_end, aclk, aresetn, st_reg == ST_DIV && cnt_reg == 6'd0, st_reg == ST_OUT, "divide did not finish")
endmodule
`default_nettype wire

// ===== design/tri_element_stiffness.sv =====
// Top level of the linear triangle element stiffness block.
// Depends on tes_pkg, tes_front, tes_queue, tes_back.
//
// channel  dir  tdata (low bit up)                                  tuser/tlast
// s_       in   x0 y0 x1 y1 x2 y2 (32 each), node0..2 (16 each)     -
// m_       out  row_index(16) col_index(16) stiffness_value(48)     degenerate / last
//
// One triangle takes an accept state and the determinant states, then, per result, the
// product states, the radix-2 divider and an output state; a degenerate one, or a result
// that saturates, skips the divider. The single shared divider sets the pace, and a
// full output register adds its stall to the output state.
// Reset is synchronous, active low, and clears all handshake state.
// A two-entry queue lets the front take requests while the back is busy.
`default_nettype none
module tri_element_stiffness #(
    parameter int NODE_INDEX_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [239:0] s_tdata,   // x_first y_first x_second y_second x_third y_third
                                         // node_first node_second node_third
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [79:0]       m_tdata,   // row_index col_index stiffness_value
    output logic              m_tlast,
    output logic              m_tuser    // degenerate
);
    logic           f_valid, f_ready, b_valid, b_ready;
    tes_pkg::elem_t f_elem, b_elem;

    tes_front #(.NODE_INDEX_BITS(NODE_INDEX_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_data(s_tdata),
        .out_valid(f_valid), .out_ready(f_ready), .out_elem(f_elem)
    );

    tes_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push_valid(f_valid), .push_ready(f_ready), .push_elem(f_elem),
        .pop_valid(b_valid), .pop_ready(b_ready), .pop_elem(b_elem)
    );

    tes_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(b_valid), .in_ready(b_ready), .in_elem(b_elem),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );
endmodule
`default_nettype wire

// ===== tb/sv/tri_element_stiffness_chk.sv =====
// Checker for the triangle element stiffness block: predicts six stiffness
// requests per accepted triangle and compares them with the result channel.
// Depends on tes_pkg for widths and the node pair tables.
`timescale 1ns / 100ps
`default_nettype none
module tri_element_stiffness_chk (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [239:0] s_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [79:0]  m_tdata,
    input  wire logic         m_tlast,
    input  wire logic         m_tuser,
    output int                pending,
    output int                errors
);
    typedef struct packed {
        logic [tes_pkg::NODE_W-1:0] row;
        logic [tes_pkg::NODE_W-1:0] col;
        logic [tes_pkg::VAL_W-1:0]  val;
        logic                       degen;
        logic                       last;
    } contrib_t;

    contrib_t contrib_q[$];

    function automatic logic [tes_pkg::VAL_W-1:0] stiff_q24(input logic signed [127:0] dot,
                                                            input logic [127:0] absdet);
        logic [127:0] mag;
        logic [127:0] quo;
        logic [127:0] lim;
        logic         neg;
        neg = dot < 0;
        mag = neg ? -dot : dot;
        quo = ((mag << 24) + absdet) / (absdet << 1);
        lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
        if (quo > lim) quo = lim;
        if (neg) quo = -quo;
        return quo[tes_pkg::VAL_W-1:0];
    endfunction

    task automatic predict_triangle(input logic [239:0] d);
        logic signed [127:0]        xs[3], ys[3], ex[3], ey[3], det, dot;
        logic [127:0]               absdet;
        logic [tes_pkg::NODE_W-1:0] nd[3];
        int                         a, b;
        contrib_t                   c;
        for (int i = 0; i < 3; i++) begin
            xs[i] = $signed(d[64*i +: 32]);
            ys[i] = $signed(d[64*i+32 +: 32]);
            nd[i] = d[192 + 16*i +: 16];
        end
        for (int i = 0; i < 3; i++) begin
            ex[i] = ys[(i+1)%3] - ys[(i+2)%3];
            ey[i] = xs[(i+2)%3] - xs[(i+1)%3];
        end
        det = (xs[1] - xs[0]) * (ys[2] - ys[0]) - (xs[2] - xs[0]) * (ys[1] - ys[0]);
        absdet = det < 0 ? -det : det;
        for (int k = 0; k < tes_pkg::PAIRS; k++) begin
            a = tes_pkg::pair_a(3'(k));
            b = tes_pkg::pair_b(3'(k));
            c.row = nd[a] > nd[b] ? nd[a] : nd[b];
            c.col = nd[a] > nd[b] ? nd[b] : nd[a];
            c.degen = det == 0;
            dot = ex[a] * ex[b] + ey[a] * ey[b];
            c.val = c.degen ? '0 : stiff_q24(dot, absdet);
            c.last = k == tes_pkg::PAIRS - 1;
            contrib_q.push_back(c);
        end
    endtask

    task automatic report(input string what, input logic [79:0] got, input logic [79:0] exp);
        $display("mismatch %s: got %h expected %h", what, got, exp);
        errors++;
    endtask

    initial errors = 0;
    assign pending = contrib_q.size();

    always @(posedge aclk) begin
        contrib_t e;
        if (aresetn) begin
            if (s_tvalid && s_tready) predict_triangle(s_tdata);
            if (m_tvalid && m_tready) begin
                if (contrib_q.size() == 0) begin
                    report("unexpected request", m_tdata, '0);
                end else begin
                    e = contrib_q.pop_front();
                    if (m_tdata[15:0] !== e.row) report("row_index", m_tdata[15:0], e.row);
                    if (m_tdata[31:16] !== e.col) report("col_index", m_tdata[31:16], e.col);
                    if (m_tdata[79:32] !== e.val)
                        report("stiffness_value", m_tdata[79:32], e.val);
                    if (m_tuser !== e.degen) report("degenerate", m_tuser, e.degen);
                    if (m_tlast !== e.last) report("last_of_element", m_tlast, e.last);
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/tri_element_stiffness_tb.sv =====
// Testbench top for the triangle element stiffness block: drives triangles,
// varies source gaps and sink stalls, and gives the verdict.
// Depends on tes_pkg, tri_element_stiffness and tri_element_stiffness_chk.
`timescale 1ns / 100ps
`default_nettype none
module tri_element_stiffness_tb;
    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [239:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;
    logic         m_tlast;
    logic         m_tuser;
    int           pending;
    int           errors;
    int           mode = 0;
    int           sent = 0;
    int           cycles = 0;
    bit           hold_done = 0;

    localparam int LIMIT = 1500000;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    tri_element_stiffness u_top (.*);

    tri_element_stiffness_chk u_chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // sink: random stalls per phase, one long hold-off to back the block up
    initial begin
        repeat (4) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!hold_done && sent >= 40) begin
                hold_done = 1;
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
            end
            case (mode)
                2: m_tready <= $urandom_range(99) >= 48;
                3: m_tready <= $urandom_range(99) >= 15;
                default: m_tready <= 1'b1;
            endcase
        end
    end

    task automatic send_triangle(input logic [31:0] x0, y0, x1, y1, x2, y2,
                                 input logic [15:0] n0, n1, n2);
        int pct;
        pct = mode == 1 ? 48 : mode == 3 ? 15 : 0;
        if ($urandom_range(99) < pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {n2, n1, n0, y2, x2, y1, x1, y0, x0};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    function automatic logic [31:0] coord(input int sh);
        return $signed($urandom()) >>> sh;
    endfunction

    initial begin
        logic [31:0] bx, by;
        int          sh;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed corners
        send_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_triangle(0, 0, 32'h10000, 0, 0, 32'h10000, 1, 2, 3);
        send_triangle(0, 0, 0, 32'h10000, 32'h10000, 0, 16'hffff, 0, 7);
        send_triangle(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                      32'h80000000, 32'h7fffffff, 16'hffff, 16'hffff, 16'hffff);
        send_triangle(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                      32'h7fffffff, 32'h80000000, 5, 5, 9);
        send_triangle(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                      32'h80000000, 32'h80000000, 0, 16'hffff, 16'h8000);
        send_triangle(0, 0, 1, 0, 0, 1, 10, 20, 30);
        send_triangle(32'h80000000, 0, 32'h7fffffff, 1, 0, 32'h80000000, 3, 2, 1);
        send_triangle(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                      32'h7fffffff, 32'h80000001, 100, 50, 100);
        send_triangle(0, 0, 32'h20000, 32'h20000, 32'h40000, 32'h40000, 4, 5, 6);
        send_triangle(32'h12345, 32'h6789, 32'h12345, 32'h6789, 32'h1, 32'h2, 1, 1, 2);
        send_triangle(0, 0, 1, 0, 32'h7fffffff, 1, 9, 8, 7);
        send_triangle(32'hffffffff, 32'hffffffff, 32'h10000, 32'hffff0000,
                      32'h55555555, 32'haaaaaaaa, 16'h5555, 16'haaaa, 16'h1234);
        for (int i = 0; i < 400; i++) begin
            mode = (i / 50) % 4;
            sh = $urandom_range(31);
            bx = coord(0);
            by = coord(0);
            if ($urandom_range(9) == 0)
                send_triangle(bx, by, bx, by, bx + coord(sh), by + coord(sh),
                              $urandom, $urandom, $urandom);
            else if ($urandom_range(19) == 0)
                send_triangle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom);
            else
                send_triangle(bx, by, bx + coord(sh), by + coord(sh), bx + coord(sh),
                              by + coord(sh), $urandom_range(31), $urandom, $urandom);
        end
        s_tvalid <= 1'b0;
        mode = 0;
        while (pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+design
design/tes_pkg.sv
design/tes_front.sv
design/tes_queue.sv
design/tes_back.sv
design/tri_element_stiffness.sv
tb/sv/tri_element_stiffness_chk.sv
tb/sv/tri_element_stiffness_tb.sv
